// ===== rtl/core/frame_pacing_statistics_defines.svh =====
// ----------------------------------------------------------------------------
// Frame pacing statistics assertion macros
// Property templates shared by the checkers of the frame pacing block.
// ----------------------------------------------------------------------------
`ifndef FRAME_PACING_STATISTICS_DEFINES_SVH
`define FRAME_PACING_STATISTICS_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define FPS_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define FPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fps_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame pacing statistics package
// Word types and fixed constants of the frame pacing statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fps_pkg;

	localparam int TIME_W     = 24;
	localparam int SUM_W      = 48;
	localparam int RATE_W     = 32;
	localparam int PCT_W      = 32;
	localparam int NUM_W      = 63;
	localparam int STEP_W     = 6;
	localparam int RATE_MUL_W = 10;
	localparam int RATE_SHIFT = 18;

	localparam logic [RATE_MUL_W-1:0] RATE_MUL = RATE_MUL_W'(1000);
	localparam logic [PCT_W-1:0]      PCT_ONE  = PCT_W'(25600);
	localparam logic [TIME_W-1:0]     TIME_MAX = '1;
	localparam logic [PCT_W-1:0]      PCT_MIN  = {1'b1, {(PCT_W-1){1'b0}}};
	localparam logic [NUM_W-1:0]      PCT_LIMIT =
		NUM_W'(PCT_ONE) + (NUM_W'(1) << (PCT_W - 1));

	typedef struct packed {
		logic [TIME_W-1:0] frame_time;
		logic              last_frame;
	} fps_in_t;

	typedef struct packed {
		logic [TIME_W-1:0]       frame_count;
		logic [TIME_W-1:0]       avg_frame_time;
		logic [RATE_W-1:0]       avg_rate;
		logic signed [PCT_W-1:0] smoothness_pct;
		logic                    saturated;
	} fps_out_t;

endpackage

// ===== rtl/core/frame_pacing_statistics.sv =====
// ----------------------------------------------------------------------------
// Frame pacing statistics
// Run statistics over frame times: count, average time, average rate and
// smoothness, computed with one shared restoring divider.
// ----------------------------------------------------------------------------
// channel  | direction | handshake            | word
// in       | input     | in_valid / in_ready  | fps_in_t: frame_time, last_frame
// out      | output    | out_valid/ out_ready | fps_out_t: count, averages, flag
//
// Frame after the first: ST_IDLE, ST_DIV (one divider bit a cycle), then ST_POST.
// First frame or zero previous time: ST_IDLE, then ST_POST, with no division.
// Last frame adds the three final divisions: average time, average rate, smoothness.
// Reset clears all statistics; in_ready is high only when the divider is free.
// A held result holds the next summary in ST_FIN, and the input with it, until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_pacing_statistics #(
	parameter int COUNT_BITS    = 24,
	parameter int FRACTION_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fps_pkg::fps_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output fps_pkg::fps_out_t out_data
);

	import fps_pkg::*;

	localparam int DEN_W = (COUNT_BITS + FRACTION_BITS > SUM_W) ?
		COUNT_BITS + FRACTION_BITS : SUM_W;
	localparam int DEV_W      = TIME_W + FRACTION_BITS;
	localparam int CNTK_W     = COUNT_BITS + RATE_MUL_W;
	localparam int RATE_NUM_W = CNTK_W + RATE_SHIFT;
	localparam int CNT_OUT_W  = (COUNT_BITS > TIME_W) ? COUNT_BITS : TIME_W;

	localparam logic [STEP_W-1:0] STEPS_DEV    = STEP_W'(DEV_W);
	localparam logic [STEP_W-1:0] STEPS_AVG    = STEP_W'(SUM_W);
	localparam logic [STEP_W-1:0] STEPS_RATE   = STEP_W'(RATE_NUM_W);
	localparam logic [STEP_W-1:0] STEPS_SMOOTH = STEP_W'(NUM_W);
	localparam logic [NUM_W-1:0]  DEV_MAX      = NUM_W'({DEV_W{1'b1}});

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_POST,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		OP_DEV,
		OP_AVG,
		OP_RATE,
		OP_SMOOTH
	} op_t;

	state_t                  state_q;
	op_t                     op_q;
	logic [COUNT_BITS-1:0]   count_q;
	logic [SUM_W-1:0]        time_sum_q;
	logic [SUM_W-1:0]        dev_sum_q;
	logic [TIME_W-1:0]       prev_q;
	logic                    seen_q;
	logic                    ovf_q;
	logic                    last_q;
	logic [NUM_W-1:0]        n_q;
	logic [DEN_W-1:0]        rem_q;
	logic [DEN_W-1:0]        den_q;
	logic [STEP_W-1:0]       step_q;
	logic [TIME_W-1:0]       avg_q;
	logic [RATE_W-1:0]       rate_q;
	logic [PCT_W-1:0]        smooth_q;
	logic                    out_valid_q;
	fps_out_t                out_q;

	logic [DEN_W:0]          partial;
	logic [DEN_W:0]          sub;
	logic                    ge;
	logic [DEN_W-1:0]        rem_nx;
	logic [NUM_W-1:0]        n_nx;
	logic [TIME_W-1:0]       t;
	logic [TIME_W-1:0]       diff;
	logic [SUM_W:0]          ts_sum;
	logic [SUM_W:0]          ds_sum;
	logic                    ovf_in;
	logic [CNTK_W-1:0]       cnt_k;
	logic [NUM_W-1:0]        n_avg;
	logic [NUM_W-1:0]        n_rate;
	logic [NUM_W-1:0]        n_smooth;
	logic [CNT_OUT_W-1:0]    cnt_w;
	logic [TIME_W-1:0]       cnt_out;
	logic [SUM_W-1:0]        q_avg;
	logic [RATE_NUM_W-1:0]   q_rate;

	always_comb begin
		partial = {rem_q, n_q[NUM_W-1]};
		sub     = partial - {1'b0, den_q};
		ge      = partial >= {1'b0, den_q};
		rem_nx  = ge ? sub[DEN_W-1:0] : partial[DEN_W-1:0];
		n_nx    = {n_q[NUM_W-2:0], ge};

		t        = in_data.frame_time;
		diff     = (t >= prev_q) ? t - prev_q : prev_q - t;
		ts_sum   = {1'b0, time_sum_q} + (SUM_W+1)'(t);
		ds_sum   = {1'b0, dev_sum_q} + (SUM_W+1)'(n_q[DEV_W-1:0]);
		ovf_in   = (&count_q) | ts_sum[SUM_W] | (seen_q & (prev_q == '0));
		cnt_k    = CNTK_W'(count_q) * CNTK_W'(RATE_MUL);
		n_avg    = NUM_W'(time_sum_q) << (NUM_W - SUM_W);
		n_rate   = NUM_W'(cnt_k) << (NUM_W - CNTK_W);
		n_smooth = NUM_W'(dev_sum_q) * NUM_W'(PCT_ONE);
		cnt_w    = CNT_OUT_W'(count_q);
		cnt_out  = (cnt_w > CNT_OUT_W'(TIME_MAX)) ? TIME_MAX : cnt_w[TIME_W-1:0];
		q_avg    = n_q[SUM_W-1:0];
		q_rate   = n_q[RATE_NUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_DEV;
			count_q     <= '0;
			time_sum_q  <= '0;
			dev_sum_q   <= '0;
			prev_q      <= '0;
			seen_q      <= 1'b0;
			ovf_q       <= 1'b0;
			last_q      <= 1'b0;
			n_q         <= '0;
			rem_q       <= '0;
			den_q       <= '0;
			step_q      <= '0;
			avg_q       <= '0;
			rate_q      <= '0;
			smooth_q    <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (ovf_in) begin
							ovf_q <= 1'b1;
						end
						if (!(&count_q)) begin
							count_q <= count_q + 1'b1;
						end
						if (ts_sum[SUM_W]) begin
							time_sum_q <= '1;
						end else begin
							time_sum_q <= ts_sum[SUM_W-1:0];
						end
						prev_q <= t;
						seen_q <= 1'b1;
						last_q <= in_data.last_frame;
						op_q   <= OP_DEV;
						rem_q  <= '0;
						den_q  <= DEN_W'(prev_q);
						step_q <= STEPS_DEV;
						if (!seen_q) begin
							n_q     <= '0;
							state_q <= ST_POST;
						end else if (prev_q == '0) begin
							n_q     <= DEV_MAX;
							state_q <= ST_POST;
						end else begin
							n_q     <= NUM_W'(diff) << (NUM_W - TIME_W);
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					n_q    <= n_nx;
					rem_q  <= rem_nx;
					step_q <= step_q - 1'b1;
					if (step_q == STEP_W'(1)) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					rem_q <= '0;
					unique case (op_q)
						OP_DEV: begin
							if (ds_sum[SUM_W]) begin
								dev_sum_q <= '1;
								ovf_q     <= 1'b1;
							end else begin
								dev_sum_q <= ds_sum[SUM_W-1:0];
							end
							if (last_q) begin
								op_q    <= OP_AVG;
								n_q     <= n_avg;
								den_q   <= DEN_W'(count_q);
								step_q  <= STEPS_AVG;
								state_q <= ST_DIV;
							end else begin
								state_q <= ST_IDLE;
							end
						end
						OP_AVG: begin
							avg_q   <= (|q_avg[SUM_W-1:TIME_W]) ? TIME_MAX : q_avg[TIME_W-1:0];
							op_q    <= OP_RATE;
							n_q     <= n_rate;
							den_q   <= DEN_W'(time_sum_q);
							step_q  <= STEPS_RATE;
							state_q <= ST_DIV;
						end
						OP_RATE: begin
							if (time_sum_q == '0 || |q_rate[RATE_NUM_W-1:RATE_W]) begin
								rate_q <= '1;
							end else begin
								rate_q <= q_rate[RATE_W-1:0];
							end
							op_q    <= OP_SMOOTH;
							n_q     <= n_smooth;
							den_q   <= DEN_W'({count_q, {FRACTION_BITS{1'b0}}});
							step_q  <= STEPS_SMOOTH;
							state_q <= ST_DIV;
						end
						OP_SMOOTH: begin
							smooth_q <= (n_q >= PCT_LIMIT) ? PCT_MIN : PCT_ONE - n_q[PCT_W-1:0];
							state_q  <= ST_FIN;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_q.frame_count    <= cnt_out;
						out_q.avg_frame_time <= avg_q;
						out_q.avg_rate       <= rate_q;
						out_q.smoothness_pct <= smooth_q;
						out_q.saturated      <= ovf_q;
						out_valid_q          <= 1'b1;
						count_q              <= '0;
						time_sum_q           <= '0;
						dev_sum_q            <= '0;
						prev_q               <= '0;
						seen_q               <= 1'b0;
						ovf_q                <= 1'b0;
						last_q               <= 1'b0;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/core/fps_checker.sv =====
// ----------------------------------------------------------------------------
// Frame pacing statistics checker
// Port-level properties of the frame pacing block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "frame_pacing_statistics_defines.svh"

module fps_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input fps_pkg::fps_out_t out_data
);

	import fps_pkg::*;

	`FPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word dropped or changed while stalled")
	`FPS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while divider busy")
	`FPS_ASSERT_IMPLY(a_count_nonzero, out_valid, out_data.frame_count != '0, "result word with zero frames")
	`FPS_ASSERT_IMPLY(a_smooth_bound, out_valid, out_data.smoothness_pct <= $signed(PCT_ONE), "smoothness above one hundred percent")

endmodule

bind frame_pacing_statistics fps_checker u_fps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
